@@ rtl/core/olte_pkg.sv @@
// Shared types and constants of the ordered line table.
package olte_pkg;

  localparam int unsigned FUNC_W         = 3;
  localparam int unsigned POS_W          = 11;
  localparam int unsigned WORD_W         = 64;
  localparam int unsigned STAT_W         = 2;
  localparam int unsigned DEPTH_DEF      = 1024;
  localparam int unsigned LINE_WIDTH_DEF = 64;

  typedef enum logic [FUNC_W-1:0] {
    FN_READ    = 3'd0,
    FN_REPLACE = 3'd1,
    FN_INSERT  = 3'd2,
    FN_DELETE  = 3'd3,
    FN_CLEAR   = 3'd4
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] line_word;
  } in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [WORD_W-1:0] read_word;
    logic [POS_W-1:0]  line_count;
  } out_t;

endpackage

@@ rtl/core/olte_ram.sv @@
// Generic simple dual-port RAM with registered read.
module olte_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/olte_ctrl.sv @@
// Sequencer and shared pointer unit that check, shift and update the line table.
module olte_ctrl #(
  parameter int unsigned DEPTH      = olte_pkg::DEPTH_DEF,
  parameter int unsigned LINE_WIDTH = olte_pkg::LINE_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  olte_pkg::in_t            in_i,
  output logic                     in_stall_o,
  output logic                     res_valid_o,
  output olte_pkg::out_t           res_o,
  input  logic                     res_take_i,
  output logic                     ram_we_o,
  output logic [$clog2(DEPTH)-1:0] ram_waddr_o,
  output logic [LINE_WIDTH-1:0]    ram_wdata_o,
  output logic                     ram_re_o,
  output logic [$clog2(DEPTH)-1:0] ram_raddr_o,
  input  logic [LINE_WIDTH-1:0]    ram_rdata_i
);

  import olte_pkg::*;

  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECIDE = 7'b0000010,
    S_RDWAIT = 7'b0000100,
    S_SHIFT  = 7'b0001000,
    S_DRAIN  = 7'b0010000,
    S_WRWORD = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_e;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                wr_pend_q, wr_pend_d;
  logic [FUNC_W-1:0]   op_q, op_d;
  logic [CMP_W-1:0]    pos_q, pos_d;
  logic [LINE_WIDTH-1:0] word_q, word_d;
  logic [AW-1:0]       ptr_q, ptr_d;
  logic [AW-1:0]       last_q, last_d;
  logic [AW-1:0]       wr_addr_q, wr_addr_d;
  logic                dir_up_q, dir_up_d;
  status_e             status_q, status_d;
  logic [WORD_W-1:0]   rd_word_q, rd_word_d;

  logic [CMP_W-1:0]    cnt_ext;
  logic [AW-1:0]       pos_aw;
  logic [AW-1:0]       cnt_m1;
  logic [AW-1:0]       ptr_inc;
  logic [AW-1:0]       ptr_dec;
  logic                at_last;
  logic                accept;

  assign cnt_ext = CMP_W'(cnt_q);
  assign pos_aw  = pos_q[AW-1:0];
  assign cnt_m1  = AW'(cnt_q - CNT_W'(1));
  assign ptr_inc = ptr_q + AW'(1);
  assign ptr_dec = ptr_q - AW'(1);
  assign at_last = (ptr_q == last_q);
  assign accept  = in_valid_i && (state_q == S_IDLE);

  assign in_stall_o  = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_FINISH);
  assign res_o.status     = status_q;
  assign res_o.read_word  = rd_word_q;
  assign res_o.line_count = POS_W'(cnt_q);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    wr_pend_d   = wr_pend_q;
    op_d        = op_q;
    pos_d       = pos_q;
    word_d      = word_q;
    ptr_d       = ptr_q;
    last_d      = last_q;
    wr_addr_d   = wr_addr_q;
    dir_up_d    = dir_up_q;
    status_d    = status_q;
    rd_word_d   = rd_word_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = wr_addr_q;
    ram_wdata_o = ram_rdata_i;
    ram_re_o    = 1'b0;
    ram_raddr_o = ptr_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d    = in_i.func;
          pos_d   = CMP_W'(in_i.position);
          word_d  = LINE_WIDTH'(in_i.line_word);
          state_d = S_DECIDE;
        end
      end

      S_DECIDE: begin
        status_d  = ST_OK;
        rd_word_d = '0;
        wr_pend_d = 1'b0;
        state_d   = S_FINISH;
        unique case (op_q)
          FN_READ: begin
            if (pos_q >= cnt_ext) begin
              status_d = ST_RANGE;
            end else begin
              ram_re_o    = 1'b1;
              ram_raddr_o = pos_aw;
              state_d     = S_RDWAIT;
            end
          end
          FN_REPLACE: begin
            if (pos_q >= cnt_ext) begin
              status_d = ST_RANGE;
            end else begin
              ram_we_o    = 1'b1;
              ram_waddr_o = pos_aw;
              ram_wdata_o = word_q;
            end
          end
          FN_INSERT: begin
            if (pos_q > cnt_ext) begin
              status_d = ST_RANGE;
            end else if (cnt_q == CNT_W'(DEPTH)) begin
              status_d = ST_FULL;
            end else begin
              cnt_d = cnt_q + CNT_W'(1);
              if (pos_q == cnt_ext) begin
                ram_we_o    = 1'b1;
                ram_waddr_o = pos_aw;
                ram_wdata_o = word_q;
              end else begin
                dir_up_d = 1'b1;
                ptr_d    = cnt_m1;
                last_d   = pos_aw;
                state_d  = S_SHIFT;
              end
            end
          end
          FN_DELETE: begin
            if (pos_q >= cnt_ext) begin
              status_d = ST_RANGE;
            end else begin
              cnt_d = cnt_q - CNT_W'(1);
              if (pos_aw != cnt_m1) begin
                dir_up_d = 1'b0;
                ptr_d    = pos_aw + AW'(1);
                last_d   = cnt_m1;
                state_d  = S_SHIFT;
              end
            end
          end
          FN_CLEAR: begin
            cnt_d = '0;
          end
          default: begin
          end
        endcase
      end

      S_RDWAIT: begin
        rd_word_d = WORD_W'(ram_rdata_i);
        state_d   = S_FINISH;
      end

      S_SHIFT: begin
        ram_re_o    = 1'b1;
        ram_raddr_o = ptr_q;
        ram_we_o    = wr_pend_q;
        wr_pend_d   = 1'b1;
        wr_addr_d   = dir_up_q ? ptr_inc : ptr_dec;
        if (at_last) begin
          state_d = S_DRAIN;
        end else begin
          ptr_d = dir_up_q ? ptr_dec : ptr_inc;
        end
      end

      S_DRAIN: begin
        ram_we_o  = 1'b1;
        wr_pend_d = 1'b0;
        state_d   = dir_up_q ? S_WRWORD : S_FINISH;
      end

      S_WRWORD: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = pos_aw;
        ram_wdata_o = word_q;
        state_d     = S_FINISH;
      end

      S_FINISH: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      wr_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      wr_pend_q <= wr_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    pos_q     <= pos_d;
    word_q    <= word_d;
    ptr_q     <= ptr_d;
    last_q    <= last_d;
    wr_addr_q <= wr_addr_d;
    dir_up_q  <= dir_up_d;
    status_q  <= status_d;
    rd_word_q <= rd_word_d;
  end

endmodule

@@ rtl/core/ordered_line_table_edit.sv @@
// Top level of the ordered line table: sequencer, line memory and result register.
//
// Input beats carry an operation (read, replace, insert, delete, clear), a
// position and a line word; each accepted beat yields exactly one result beat
// with a status, the word read and the line count after the operation.
// A beat is accepted when in_valid_i is high and in_stall_o is low; a result
// is taken when out_valid_o is high and out_stall_i is low.
// Items are handled one at a time. From acceptance to the result register,
// a read passes the decide, read-wait and finish states; replace, clear,
// out-of-range and full requests, an insert at the end and a delete of the
// last line pass decide and finish; any other insert or delete also runs
// the shift loop, which moves one line per cycle through the line memory
// (one read port, one write port), then a drain step, and an insert then
// writes its word. The next beat is accepted once the sequencer is idle again.
// The result register holds a finished beat while the receiver stalls; the
// next item is accepted meanwhile and completes once that register is free.
// Reset clears the line count and the sequencer; the line memory is not
// cleared, since only positions below the count can be read.
module ordered_line_table_edit #(
  parameter int unsigned DEPTH      = olte_pkg::DEPTH_DEF,
  parameter int unsigned LINE_WIDTH = olte_pkg::LINE_WIDTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  olte_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output olte_pkg::out_t out_o
);

  import olte_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  logic                  res_valid;
  out_t                  res;
  logic                  res_take;
  logic                  out_valid_q, out_valid_d;
  out_t                  out_q;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [LINE_WIDTH-1:0] ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [LINE_WIDTH-1:0] ram_rdata;

  assign res_take = !out_valid_q || !out_stall_i;

  olte_ctrl #(
    .DEPTH      (DEPTH),
    .LINE_WIDTH (LINE_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_i        (in_i),
    .in_stall_o  (in_stall_o),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_take_i  (res_take),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  olte_ram #(
    .WIDTH (LINE_WIDTH),
    .DEPTH (DEPTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_take) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule
